// ===== src/dds_frequency_stepper_top_assert.svh =====
// Assertion macros for the stepper RTL, included by the queue.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef DDS_FREQUENCY_STEPPER_TOP_ASSERT_SVH
`define DDS_FREQUENCY_STEPPER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property check
`define DFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in this cycle implies consequence in the next one
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define DFS_ASSERT(lbl, prop, msg)
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/dfs_pkg.sv =====
`default_nettype none

package dfs_pkg;

   // Field widths
   localparam int FREQ_W      = 20;
   localparam int WORD_W      = 16;
   localparam int STEP_W      = 24;
   localparam int COUNT_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_MAX          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_MIN          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COARSE_MULTIPLIER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM_GAIN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_GAIN         = 3'd5;

   // Event opcodes
   localparam logic OP_STEP    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Queue between front and back
   localparam int DFS_QUEUE_DEPTH = 4;

   // Frequency after reset
   localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd100;

   // 2^28 / 25 MHz reduces to 2^22 / 390625; remainder threshold scaled by 1/64
   localparam logic [FREQ_W-1:0] REF_DIVISOR = 20'd390625;
   localparam logic [18:0]       ROUND_LIMIT = 19'd196608;
   localparam logic [WORD_W-1:0] WORD_TAG    = 16'h4000;

   typedef struct packed {
      logic [7:0]        accel_threshold;
      logic [FREQ_W-1:0] freq_max;
      logic [FREQ_W-1:0] freq_min;
      logic [15:0]       coarse_multiplier;
      logic [7:0]        medium_gain;
      logic [7:0]        fast_gain;
   } dfs_config_type;

   localparam dfs_config_type CFG_RESET = '{
      accel_threshold:   8'd15,
      freq_max:          20'd999999,
      freq_min:          20'd1,
      coarse_multiplier: 16'd1000,
      medium_gain:       8'd5,
      fast_gain:         8'd20
   };

   typedef struct packed {
      logic full;
      logic empty;
   } dfs_queue_status_type;

endpackage

`default_nettype wire

// ===== src/dfs_front.sv =====
`default_nettype none

module dfs_front (
   input  wire                          clock,
   input  wire                          reset,
   input  dfs_pkg::dfs_config_type      cfg,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_opcode,
   input  wire                          req_direction_up,
   input  wire                          req_coarse,
   input  wire                          req_still_held,
   input  dfs_pkg::dfs_queue_status_type q_status,
   output logic                         q_push,
   output logic [dfs_pkg::FREQ_W-1:0]   q_push_data
);
   import dfs_pkg::*;

   // Hold counters and frequency state
   logic [COUNT_W-1:0] first_count_ff, first_count_in;
   logic [COUNT_W-1:0] second_count_ff, second_count_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;

   // Classified event waiting for the frequency update
   logic               a_valid_ff;
   logic               a_release_ff;
   logic               a_up_ff;
   logic               a_accel_ff;
   logic [STEP_W-1:0]  a_step_ff;

   logic               advance;
   logic               accept;
   logic               accel;
   logic [7:0]         gain;
   logic [15:0]        base;
   logic [STEP_W-1:0]  step_in;

   logic               move;
   logic signed [25:0] freq_s;
   logic signed [25:0] moved_s;
   logic signed [25:0] hi_clamped_s;
   logic signed [25:0] lo_clamped_s;

   assign advance   = !a_valid_ff || !q_status.full;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Classify the event and form the accelerated step
   always_comb begin
      accel = first_count_ff >= cfg.accel_threshold;
      if (!accel) begin
         gain = 8'd1;
      end else if (second_count_ff >= cfg.accel_threshold) begin
         gain = cfg.fast_gain;
      end else begin
         gain = cfg.medium_gain;
      end
      base    = req_coarse ? cfg.coarse_multiplier : 16'd1;
      step_in = STEP_W'(base) * STEP_W'(gain);
   end

   // Counter update on each accepted event
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      if (req_opcode == OP_RELEASE) begin
         first_count_in  = '0;
         second_count_in = '0;
      end else if (req_still_held) begin
         if (first_count_ff < cfg.accel_threshold) begin
            first_count_in = first_count_ff + 1'b1;
         end else if (second_count_ff < cfg.accel_threshold) begin
            second_count_in = second_count_ff + 1'b1;
         end
      end
   end

   // Frequency move and clamp
   always_comb begin
      freq_s  = $signed({6'b0, freq_ff});
      move    = a_accel_ff || a_up_ff || (freq_ff > cfg.freq_min);
      moved_s = freq_s;
      if (move) begin
         moved_s = a_up_ff ? freq_s + $signed({2'b0, a_step_ff})
                           : freq_s - $signed({2'b0, a_step_ff});
      end
      hi_clamped_s = (moved_s > $signed({6'b0, cfg.freq_max})) ?
                     $signed({6'b0, cfg.freq_max}) : moved_s;
      lo_clamped_s = (hi_clamped_s < $signed({6'b0, cfg.freq_min})) ?
                     $signed({6'b0, cfg.freq_min}) : hi_clamped_s;
      freq_in      = a_release_ff ? freq_ff : lo_clamped_s[FREQ_W-1:0];
   end

   assign q_push      = a_valid_ff && !q_status.full;
   assign q_push_data = freq_in;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         freq_ff         <= FREQ_RESET;
      end else begin
         if (advance) begin
            a_valid_ff <= req_valid;
         end
         if (accept) begin
            first_count_ff  <= first_count_in;
            second_count_ff <= second_count_in;
         end
         if (q_push) begin
            freq_ff <= freq_in;
         end
      end
   end

   // Event payload
   always_ff @(posedge clock) begin
      if (accept) begin
         a_release_ff <= (req_opcode == OP_RELEASE);
         a_up_ff      <= req_direction_up;
         a_accel_ff   <= accel;
         a_step_ff    <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/dfs_queue.sv =====
`default_nettype none
`include "dds_frequency_stepper_top_assert.svh"

module dfs_queue #(
   parameter int DEPTH = dfs_pkg::DFS_QUEUE_DEPTH
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   input  wire  [dfs_pkg::FREQ_W-1:0]    push_data,
   input  wire                           pop,
   output logic [dfs_pkg::FREQ_W-1:0]    pop_data,
   output dfs_pkg::dfs_queue_status_type status
);
   import dfs_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [FREQ_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      case ({push, pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DFS_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `DFS_ASSERT(a_no_push_full, push |-> !status.full, "transfer into a full queue")
   `DFS_ASSERT(a_no_pop_empty, pop |-> !status.empty, "transfer out of an empty queue")
   `DFS_ASSERT_NEXT(a_count_up, push && !pop, count_ff == CNT_W'($past(count_ff) + 1'b1), "queue count did not rise on push")

endmodule

`default_nettype wire

// ===== src/dfs_back.sv =====
`default_nettype none

module dfs_back (
   input  wire                           clock,
   input  wire                           reset,
   input  dfs_pkg::dfs_queue_status_type q_status,
   input  wire  [dfs_pkg::FREQ_W-1:0]    q_pop_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [dfs_pkg::FREQ_W-1:0]    rsp_frequency_hz,
   output logic [dfs_pkg::WORD_W-1:0]    rsp_lsb_word,
   output logic [dfs_pkg::WORD_W-1:0]    rsp_msb_word
);
   import dfs_pkg::*;

   localparam int STAGES = 4;

   typedef struct packed {
      logic [18:0] rem;
      logic [23:0] quo;
   } div_state_type;

   // One restoring step: shift remainder, subtract divisor when it fits
   function automatic div_state_type div_step(input div_state_type s);
      logic [19:0]   shifted;
      div_state_type r;
      shifted = {s.rem, 1'b0};
      if (shifted >= REF_DIVISOR) begin
         r.rem = 19'(shifted - REF_DIVISOR);
         r.quo = {s.quo[22:0], 1'b1};
      end else begin
         r.rem = shifted[18:0];
         r.quo = {s.quo[22:0], 1'b0};
      end
      return r;
   endfunction

   logic                advance;
   logic [STAGES-1:0]   st_valid_ff;
   div_state_type       st_ff      [STAGES];
   div_state_type       st_in      [STAGES];
   logic [FREQ_W-1:0]   st_freq_ff [STAGES];

   logic                out_valid_ff;
   logic [FREQ_W-1:0]   out_freq_ff;
   logic [WORD_W-1:0]   out_lsb_ff, out_lsb_in;
   logic [WORD_W-1:0]   out_msb_ff, out_msb_in;
   logic [23:0]         word;

   // Whole pipeline moves when the output register can take a result
   assign advance = !out_valid_ff || !rsp_stall;
   assign q_pop   = advance && !q_status.empty;

   // Integer part of f / divisor (at most 2), then 22 fraction steps over 3 stages
   always_comb begin
      if (q_pop_data >= (REF_DIVISOR << 1)) begin
         st_in[0].rem = 19'(q_pop_data - (REF_DIVISOR << 1));
         st_in[0].quo = 24'd2;
      end else if (q_pop_data >= REF_DIVISOR) begin
         st_in[0].rem = 19'(q_pop_data - REF_DIVISOR);
         st_in[0].quo = 24'd1;
      end else begin
         st_in[0].rem = q_pop_data[18:0];
         st_in[0].quo = 24'd0;
      end

      st_in[1] = st_ff[0];
      for (int i = 0; i < 8; i++) begin
         st_in[1] = div_step(st_in[1]);
      end
      st_in[2] = st_ff[1];
      for (int i = 0; i < 7; i++) begin
         st_in[2] = div_step(st_in[2]);
      end
      st_in[3] = st_ff[2];
      for (int i = 0; i < 7; i++) begin
         st_in[3] = div_step(st_in[3]);
      end
   end

   // Round up on a large remainder and tag the 14-bit low half and the 10-bit high part
   always_comb begin
      word       = st_ff[STAGES-1].quo + 24'(st_ff[STAGES-1].rem >= ROUND_LIMIT);
      out_lsb_in = WORD_TAG | {2'b0, word[13:0]};
      out_msb_in = WORD_TAG | {6'b0, word[23:14]};
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         st_valid_ff  <= {st_valid_ff[STAGES-2:0], !q_status.empty};
         out_valid_ff <= st_valid_ff[STAGES-1];
      end
   end

   // Stage and output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0]      <= st_in[0];
         st_freq_ff[0] <= q_pop_data;
         for (int k = 1; k < STAGES; k++) begin
            st_ff[k]      <= st_in[k];
            st_freq_ff[k] <= st_freq_ff[k-1];
         end
         out_freq_ff <= st_freq_ff[STAGES-1];
         out_lsb_ff  <= out_lsb_in;
         out_msb_ff  <= out_msb_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frequency_hz = out_freq_ff;
   assign rsp_lsb_word     = out_lsb_ff;
   assign rsp_msb_word     = out_msb_ff;

endmodule

`default_nettype wire

// ===== src/dds_frequency_stepper_top.sv =====
// DDS frequency stepper. Each event on the req_ channel (a step or a button release)
// yields one transfer on the rsp_ channel: the frequency in hertz after the event and
// the two tagged SPI words of the 28-bit tuning word for a 25 MHz reference. The block
// takes one event per clock cycle while its queue has room. The rate is set by the
// frequency update, which is combinational on the stored frequency once the
// accelerated step has been formed and registered at intake; the tuning-word division
// runs as a four-stage pipeline behind a small queue, so a stalled rsp_ side only
// holds the req_ side once that queue has filled. Registers are to be written through
// csr_ only while the block is idle; the block does not enforce this. csr_ready is
// always high and indexes beyond the register list are ignored.
`default_nettype none

module dds_frequency_stepper_top #(
   parameter int QUEUE_DEPTH = dfs_pkg::DFS_QUEUE_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [dfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [dfs_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_opcode,
   input  wire                              req_direction_up,
   input  wire                              req_coarse,
   input  wire                              req_still_held,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [dfs_pkg::FREQ_W-1:0]       rsp_frequency_hz,
   output logic [dfs_pkg::WORD_W-1:0]       rsp_lsb_word,
   output logic [dfs_pkg::WORD_W-1:0]       rsp_msb_word
);
   import dfs_pkg::*;

   dfs_config_type       cfg_ff, cfg_in;
   dfs_queue_status_type q_status;
   logic                 q_push;
   logic                 q_pop;
   logic [FREQ_W-1:0]    q_push_data;
   logic [FREQ_W-1:0]    q_pop_data;

   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACCEL_THRESHOLD:   cfg_in.accel_threshold   = csr_data[7:0];
            CSR_FREQ_MAX:          cfg_in.freq_max          = csr_data[FREQ_W-1:0];
            CSR_FREQ_MIN:          cfg_in.freq_min          = csr_data[FREQ_W-1:0];
            CSR_COARSE_MULTIPLIER: cfg_in.coarse_multiplier = csr_data[15:0];
            CSR_MEDIUM_GAIN:       cfg_in.medium_gain       = csr_data[7:0];
            CSR_FAST_GAIN:         cfg_in.fast_gain         = csr_data[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dfs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_direction_up (req_direction_up),
      .req_coarse       (req_coarse),
      .req_still_held   (req_still_held),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   dfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   dfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_pop_data       (q_pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_lsb_word     (rsp_lsb_word),
      .rsp_msb_word     (rsp_msb_word)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_dds_frequency_stepper_top.sv =====
`timescale 1ns / 1ps

module tb_dds_frequency_stepper_top;
   import dfs_pkg::*;

   localparam int CLK_HALF_NS     = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 12;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 8;
   localparam int LONG_HOLD_PHASE = 3;
   localparam int CROSSED_PHASE   = 6;
   localparam int PHASE_EVENTS    = 140;
   localparam int LONG_EVENTS     = 600;

   localparam longint unsigned DDS_REF_HZ  = 64'd25000000;
   localparam longint unsigned ROUND_UP_AT = 64'hC00000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic [FREQ_W-1:0]      FREQ_TOP        = 20'hFFFFF;

   localparam logic DIR_UP      = 1'b1;
   localparam logic DIR_DOWN    = 1'b0;
   localparam logic STEP_COARSE = 1'b1;
   localparam logic STEP_FINE   = 1'b0;
   localparam logic BTN_HELD    = 1'b1;
   localparam logic BTN_FREE    = 1'b0;

   typedef struct packed {
      logic op;
      logic up;
      logic coarse;
      logic held;
   } tone_event_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [WORD_W-1:0] lsb;
      logic [WORD_W-1:0] msb;
   } tone_result_type;

   typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      tone_event_type         ev;
      logic                   typed;
      tone_result_type        want;
   } stim_row_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_type;

   localparam tone_event_type  NO_EVENT = '0;
   localparam tone_result_type NO_TONE  = '0;

   // Directed rows: reset value, clamps at both ends, the no-move rule at the
   // minimum, both acceleration stages, crossed clamps and zero registers
   localparam int DIRECTED_LEN = 33;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_RELEASE, DIR_DOWN, STEP_FINE, BTN_FREE},
        1'b1, '{20'd100, 16'h4432, 16'h4000}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_COARSE, BTN_FREE},
        1'b1, '{20'd1, 16'h400B, 16'h4000}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_FINE, BTN_FREE},
        1'b1, '{20'd1, 16'h400B, 16'h4000}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_UP, STEP_FINE, BTN_FREE}, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_ACCEL_THRESHOLD, 20'd1, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_COARSE_MULTIPLIER, 20'd65535, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_MEDIUM_GAIN, 20'd255, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_FAST_GAIN, 20'd255, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_UP, STEP_COARSE, BTN_HELD}, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_UP, STEP_COARSE, BTN_HELD},
        1'b1, '{20'd999999, 16'h56FF, 16'h428F}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_COARSE, BTN_HELD},
        1'b1, '{20'd1, 16'h400B, 16'h4000}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_FINE, BTN_HELD},
        1'b1, '{20'd1, 16'h400B, 16'h4000}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_RELEASE, DIR_UP, STEP_COARSE, BTN_HELD},
        1'b1, '{20'd1, 16'h400B, 16'h4000}},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_FINE, BTN_FREE},
        1'b1, '{20'd1, 16'h400B, 16'h4000}},
      '{ROW_WRITE, CSR_FREQ_MAX, 20'd1, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_FREQ_MIN, FREQ_TOP, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_UP, STEP_FINE, BTN_FREE}, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_FINE, BTN_FREE}, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_ACCEL_THRESHOLD, 20'd0, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_MEDIUM_GAIN, 20'd0, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_FAST_GAIN, 20'd0, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_COARSE_MULTIPLIER, 20'd0, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_SPARE_INDEX, FREQ_TOP, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_UP, STEP_COARSE, BTN_HELD}, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_DOWN, STEP_FINE, BTN_FREE}, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_RELEASE, DIR_DOWN, STEP_FINE, BTN_FREE}, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_ACCEL_THRESHOLD, CSR_DATA_W'(CFG_RESET.accel_threshold),
        NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_FREQ_MAX, CFG_RESET.freq_max, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_FREQ_MIN, CFG_RESET.freq_min, NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_COARSE_MULTIPLIER, CSR_DATA_W'(CFG_RESET.coarse_multiplier),
        NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_MEDIUM_GAIN, CSR_DATA_W'(CFG_RESET.medium_gain),
        NO_EVENT, 1'b0, NO_TONE},
      '{ROW_WRITE, CSR_FAST_GAIN, CSR_DATA_W'(CFG_RESET.fast_gain), NO_EVENT, 1'b0, NO_TONE},
      '{ROW_EVENT, 3'd0, 20'd0, '{OP_STEP, DIR_UP, STEP_FINE, BTN_HELD},
        1'b1, '{20'd999999, 16'h56FF, 16'h428F}}
   };

   // Clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   logic req_valid        = 1'b0;
   logic req_stall;
   logic req_opcode       = 1'b0;
   logic req_direction_up = 1'b0;
   logic req_coarse       = 1'b0;
   logic req_still_held   = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [FREQ_W-1:0] rsp_frequency_hz;
   logic [WORD_W-1:0] rsp_lsb_word;
   logic [WORD_W-1:0] rsp_msb_word;

   // Stepper state as predicted
   dfs_config_type    tone_cfg    = CFG_RESET;
   logic [FREQ_W-1:0] tone_freq   = FREQ_RESET;
   logic [7:0]        hold_first  = '0;
   logic [7:0]        hold_second = '0;

   tone_result_type pending_tones [$];

   int unsigned    cycle_count   = 0;
   int             fail_count    = 0;
   int             events_sent   = 0;
   int             tones_checked = 0;
   int             csr_writes    = 0;
   int             burst_left    = 0;
   int             stall_left    = 0;
   stall_mode_type stall_mode    = STALL_NONE;

   dds_frequency_stepper_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_direction_up (req_direction_up),
      .req_coarse       (req_coarse),
      .req_still_held   (req_still_held),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_lsb_word     (rsp_lsb_word),
      .rsp_msb_word     (rsp_msb_word)
   );

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
      fail_count++;
   endtask

   // 28-bit tuning word for a 25 MHz reference, rounded at the 0xC00000 remainder
   function automatic logic [27:0] tuning_word_of(input logic [FREQ_W-1:0] f);
      longint unsigned scaled;
      longint unsigned quot;
      longint unsigned rem;
      scaled = {44'd0, f} << 28;
      quot   = scaled / DDS_REF_HZ;
      rem    = scaled % DDS_REF_HZ;
      if (rem >= ROUND_UP_AT) quot = quot + 1;
      return quot[27:0];
   endfunction

   // Applies one event to the predicted state and returns the tone it reports
   function automatic tone_result_type advance_stepper(input tone_event_type ev);
      longint          pos;
      longint          step;
      longint          lo;
      longint          hi;
      logic            move;
      logic [27:0]     w;
      tone_result_type res;
      if (ev.op == OP_RELEASE) begin
         hold_first  = '0;
         hold_second = '0;
      end else begin
         pos  = {44'd0, tone_freq};
         lo   = {44'd0, tone_cfg.freq_min};
         hi   = {44'd0, tone_cfg.freq_max};
         step = ev.coarse ? {48'd0, tone_cfg.coarse_multiplier} : 64'd1;
         move = 1'b1;
         if (hold_first >= tone_cfg.accel_threshold) begin
            if (hold_second >= tone_cfg.accel_threshold)
               step = step * {56'd0, tone_cfg.fast_gain};
            else
               step = step * {56'd0, tone_cfg.medium_gain};
         end else if (!(pos > lo || ev.up)) begin
            // unaccelerated down step parks at the minimum
            move = 1'b0;
         end
         if (move) pos = ev.up ? pos + step : pos - step;
         // upper clamp first, so crossed limits settle on the minimum
         if (pos > hi) pos = hi;
         if (pos < lo) pos = lo;
         tone_freq = pos[FREQ_W-1:0];
         if (ev.held) begin
            if (hold_first < tone_cfg.accel_threshold)
               hold_first = hold_first + 8'd1;
            else if (hold_second < tone_cfg.accel_threshold)
               hold_second = hold_second + 8'd1;
         end
      end
      w        = tuning_word_of(tone_freq);
      res.freq = tone_freq;
      res.lsb  = WORD_TAG | {2'b00, w[13:0]};
      res.msb  = WORD_TAG | {2'b00, w[27:14]};
      return res;
   endfunction

   // Register write, mirrored into the predicted configuration on transfer
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ACCEL_THRESHOLD:   tone_cfg.accel_threshold   = data[7:0];
         CSR_FREQ_MAX:          tone_cfg.freq_max          = data[FREQ_W-1:0];
         CSR_FREQ_MIN:          tone_cfg.freq_min          = data[FREQ_W-1:0];
         CSR_COARSE_MULTIPLIER: tone_cfg.coarse_multiplier = data[15:0];
         CSR_MEDIUM_GAIN:       tone_cfg.medium_gain       = data[7:0];
         CSR_FAST_GAIN:         tone_cfg.fast_gain         = data[7:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sender pacing: bursts of random length, random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_event(input tone_event_type ev, input logic typed,
                             input tone_result_type typed_tone);
      tone_result_type want;
      req_valid        <= 1'b1;
      req_opcode       <= ev.op;
      req_direction_up <= ev.up;
      req_coarse       <= ev.coarse;
      req_still_held   <= ev.held;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = advance_stepper(ev);
      pending_tones.push_back(typed ? typed_tone : want);
      events_sent++;
      pace_sender();
   endtask

   // Drain every pending tone and let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_tones.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic tone_event_type random_event();
      tone_event_type ev;
      ev.op     = 1'($urandom_range(0, 1));
      ev.up     = 1'($urandom_range(0, 1));
      ev.coarse = 1'($urandom_range(0, 1));
      ev.held   = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   // One press: held steps, a final step on let-go, usually then a release
   task automatic run_hold_press(inout int budget);
      tone_event_type ev;
      int             presses;
      int             thr;
      thr       = int'(tone_cfg.accel_threshold);
      ev.op     = OP_STEP;
      ev.up     = 1'($urandom_range(0, 1));
      ev.coarse = ($urandom_range(0, 3) == 0);
      presses   = $urandom_range(0, 1) ? $urandom_range(2 * thr, 2 * thr + 4)
                                       : $urandom_range(1, 2 * thr + 4);
      if (presses > budget) presses = (budget > 0) ? budget : 1;
      for (int i = 0; i < presses; i++) begin
         if ($urandom_range(0, 15) == 0) ev.up = !ev.up;
         ev.held = (i != presses - 1);
         send_event(ev, 1'b0, NO_TONE);
         budget--;
      end
      if ($urandom_range(0, 4) != 0) begin
         ev      = random_event();
         ev.op   = OP_RELEASE;
         send_event(ev, 1'b0, NO_TONE);
         budget--;
      end
   endtask

   function automatic logic [7:0] random_gain();
      case ($urandom_range(0, 3))
         0:       return 8'd1;
         1:       return 8'd255;
         default: return 8'($urandom_range(2, 30));
      endcase
   endfunction

   // Register setting for one random phase; the last one returns to reset values
   task automatic program_phase(input int p);
      dfs_config_type cfg;
      int             pick;
      cfg.accel_threshold = (p == 0) ? 8'd1 :
                            (p == LONG_HOLD_PHASE) ? 8'd255 : 8'($urandom_range(1, 12));
      pick = (p == 0) ? 0 : $urandom_range(0, 3);
      case (pick)
         0: begin
            cfg.freq_max = FREQ_TOP;
            cfg.freq_min = 20'd1;
         end
         1: begin
            cfg.freq_max = FREQ_W'($urandom_range(1000, FREQ_TOP));
            cfg.freq_min = FREQ_W'($urandom_range(1, cfg.freq_max - 1));
         end
         2: begin
            cfg.freq_min = FREQ_W'($urandom_range(1, 1040000));
            cfg.freq_max = FREQ_W'(cfg.freq_min + $urandom_range(0, 3000));
         end
         default: begin
            cfg.freq_max = CFG_RESET.freq_max;
            cfg.freq_min = CFG_RESET.freq_min;
         end
      endcase
      if (p == CROSSED_PHASE) begin
         cfg.freq_min = FREQ_W'($urandom_range(2, FREQ_TOP));
         cfg.freq_max = FREQ_W'($urandom_range(1, cfg.freq_min - 1));
      end
      case ($urandom_range(0, 3))
         0:       cfg.coarse_multiplier = 16'd1;
         1:       cfg.coarse_multiplier = 16'd65535;
         2:       cfg.coarse_multiplier = 16'($urandom_range(1, 65535));
         default: cfg.coarse_multiplier = 16'($urandom_range(1, 50));
      endcase
      cfg.medium_gain = random_gain();
      cfg.fast_gain   = random_gain();
      if (p == RANDOM_PHASES - 1) cfg = CFG_RESET;
      write_register(CSR_ACCEL_THRESHOLD, CSR_DATA_W'(cfg.accel_threshold));
      write_register(CSR_FREQ_MAX, cfg.freq_max);
      write_register(CSR_FREQ_MIN, cfg.freq_min);
      write_register(CSR_COARSE_MULTIPLIER, CSR_DATA_W'(cfg.coarse_multiplier));
      write_register(CSR_MEDIUM_GAIN, CSR_DATA_W'(cfg.medium_gain));
      write_register(CSR_FAST_GAIN, CSR_DATA_W'(cfg.fast_gain));
   endtask

   // Result side stalls in random modes, each kept for a random span before it changes
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 200);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         default:      rsp_stall <= stall_left[4];
      endcase
   end

   // Check each result transfer against the oldest pending tone
   always @(posedge clock) begin : tone_check
      tone_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_tones.size() == 0) begin
            report_mismatch("result with nothing pending, frequency", 32'(rsp_frequency_hz), 0);
         end else begin
            want = pending_tones.pop_front();
            if (rsp_frequency_hz !== want.freq)
               report_mismatch("frequency_hz", 32'(rsp_frequency_hz), 32'(want.freq));
            if (rsp_lsb_word !== want.lsb)
               report_mismatch("lsb_word", 32'(rsp_lsb_word), 32'(want.lsb));
            if (rsp_msb_word !== want.msb)
               report_mismatch("msb_word", 32'(rsp_msb_word), 32'(want.msb));
            tones_checked++;
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("cycle limit reached with %0d results outstanding", pending_tones.size());
      $display("dds_frequency_stepper_top verification failed");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      int           budget;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            write_register(row.idx, row.data);
         end else begin
            send_event(row.ev, row.typed, row.want);
         end
      end

      // Random phases, mostly press-and-hold sequences with some noise
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         program_phase(p);
         budget = (p == LONG_HOLD_PHASE) ? LONG_EVENTS : PHASE_EVENTS;
         while (budget > 0) begin
            if ($urandom_range(0, 4) != 0) begin
               run_hold_press(budget);
            end else begin
               send_event(random_event(), 1'b0, NO_TONE);
               budget--;
            end
         end
      end

      wait_idle();
      $display("covered %0d events (%0d directed rows), %0d results checked", events_sent,
               DIRECTED_LEN, tones_checked);
      $display("%0d register writes over %0d random settings plus directed clamp and gain cases",
               csr_writes, RANDOM_PHASES);
      if (fail_count == 0)
         $display("dds_frequency_stepper_top verification clean");
      else
         $display("dds_frequency_stepper_top verification failed");
      $finish;
   end

endmodule
